@@ design/tal_pkg.sv @@
`default_nettype none
package tal_pkg;

    localparam int H_RES     = 1024;
    localparam int V_RES     = 1024;
    localparam int MAX_WIDTH = 15;

    localparam int CW    = 13;
    localparam int PW    = 14;
    localparam int LVW   = 8;
    localparam int COLW  = 16;
    localparam int WW    = 4;
    localparam int HW    = 3;
    localparam int KW    = 5;
    localparam int ROWW  = 5;
    localparam int FQW   = 24;
    localparam int ERRW  = 15;
    localparam int NUMW  = 21;
    localparam int DENW  = 13;
    localparam int QW    = 9;
    localparam int DCW   = 5;
    localparam int TBLW  = 12;

    localparam logic CMD_START = 1'b0;
    localparam logic CMD_STEP  = 1'b1;

    localparam int   CFG_IDX_W      = 1;
    localparam logic CFG_LINE_WIDTH = 1'b0;
    localparam logic CFG_ANTIALIAS  = 1'b1;

    typedef struct packed {
        logic start_load;
        logic step_load;
        logic setup1;
        logic setup2;
        logic calc;
        logic mul;
        logic emit;
        logic step_end;
    } t_cmd;

    typedef struct packed {
        logic mode_idle;
        logic dot;
        logic aa;
        logic div_done;
        logic pix_last;
        logic out_free;
    } t_stat;

    // ceil(255 * sqrt(d)) for d = 0..63
    localparam logic [TBLW-1:0] SQRT_TBL [64] = '{
        12'd0,    12'd255,  12'd361,  12'd442,  12'd510,  12'd571,  12'd625,  12'd675,
        12'd722,  12'd765,  12'd807,  12'd846,  12'd884,  12'd920,  12'd955,  12'd988,
        12'd1020, 12'd1052, 12'd1082, 12'd1112, 12'd1141, 12'd1169, 12'd1197, 12'd1223,
        12'd1250, 12'd1275, 12'd1301, 12'd1326, 12'd1350, 12'd1374, 12'd1397, 12'd1420,
        12'd1443, 12'd1465, 12'd1487, 12'd1509, 12'd1530, 12'd1552, 12'd1572, 12'd1593,
        12'd1613, 12'd1633, 12'd1653, 12'd1673, 12'd1692, 12'd1711, 12'd1730, 12'd1749,
        12'd1767, 12'd1785, 12'd1804, 12'd1822, 12'd1839, 12'd1857, 12'd1874, 12'd1892,
        12'd1909, 12'd1926, 12'd1943, 12'd1959, 12'd1976, 12'd1992, 12'd2008, 12'd2024
    };

    function automatic logic [COLW-1:0] grey565(input logic [LVW-1:0] v);
        return {v[7:3], v[7:2], v[7:3]};
    endfunction

    function automatic logic [LVW-1:0] div255(input logic [COLW-1:0] p);
        logic [COLW:0] t;
        t = {1'b0, p} + 17'd1 + {9'd0, p[15:8]};
        return t[15:8];
    endfunction

    function automatic logic on_screen(input logic signed [PW-1:0] x,
                                       input logic signed [PW-1:0] y);
        return !x[PW-1] && ($unsigned(x) < PW'(H_RES)) &&
               !y[PW-1] && ($unsigned(y) < PW'(V_RES));
    endfunction

endpackage
`default_nettype wire

@@ design/tal_div.sv @@
`default_nettype none
module tal_div (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    input  wire logic [tal_pkg::NUMW-1:0]   i_num,
    input  wire logic [tal_pkg::DENW-1:0]   i_den,
    output logic                            o_done,
    output logic [tal_pkg::QW-1:0]          o_quot
);

    logic                        r_busy;
    logic                        r_done;
    logic [tal_pkg::DCW-1:0]     r_cnt;
    logic [tal_pkg::DENW-1:0]    r_rem;
    logic [tal_pkg::DENW-1:0]    r_den;
    logic [tal_pkg::NUMW-1:0]    r_nq;
    logic [tal_pkg::DENW:0]      trial;
    logic                        ge;

    assign trial = {r_rem, r_nq[tal_pkg::NUMW-1]};
    assign ge    = trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == tal_pkg::DCW'(tal_pkg::NUMW - 1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == tal_pkg::DCW'(tal_pkg::NUMW - 1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_den <= i_den;
            r_nq  <= i_num;
        end else if (r_busy) begin
            r_rem <= ge ? tal_pkg::DENW'(trial - {1'b0, r_den}) : trial[tal_pkg::DENW-1:0];
            r_nq  <= {r_nq[tal_pkg::NUMW-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_nq[tal_pkg::QW-1:0];

endmodule
`default_nettype wire

@@ design/tal_dp.sv @@
`default_nettype none
module tal_dp (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire tal_pkg::t_cmd                 i_cmd,
    output tal_pkg::t_stat                     o_stat,
    input  wire logic signed [tal_pkg::CW-1:0] i_x_start,
    input  wire logic signed [tal_pkg::CW-1:0] i_y_start,
    input  wire logic signed [tal_pkg::CW-1:0] i_x_end,
    input  wire logic signed [tal_pkg::CW-1:0] i_y_end,
    input  wire logic [tal_pkg::LVW-1:0]       i_brightness,
    input  wire logic [tal_pkg::WW-1:0]        i_line_width,
    input  wire logic                          i_antialias_on,
    input  wire logic                          i_out_stall,
    output logic                               o_out_valid,
    output logic signed [tal_pkg::PW-1:0]      o_pixel_x,
    output logic signed [tal_pkg::PW-1:0]      o_pixel_y,
    output logic [tal_pkg::COLW-1:0]           o_pixel_color,
    output logic                               o_write_enable,
    output logic                               o_group_last,
    output logic                               o_line_done
);

    localparam int PW = tal_pkg::PW;

    typedef enum logic [1:0] {M_IDLE, M_PLAIN, M_AA, M_DOT} t_mode;

    t_mode                           r_mode;
    logic signed [PW-1:0]            r_x0, r_y0, r_x1, r_y1;
    logic [tal_pkg::LVW-1:0]         r_level;
    logic [tal_pkg::HW-1:0]          r_half;
    logic                            r_aa;
    logic                            r_swap;
    logic signed [PW-1:0]            r_maj_pos, r_maj_fin, r_min_pos;
    logic signed [tal_pkg::FQW-1:0]  r_min_fq;
    logic signed [tal_pkg::ERRW-1:0] r_err;
    logic [PW-1:0]                   r_maj_d, r_min_d;
    logic                            r_dir;
    logic [tal_pkg::QW-1:0]          r_grad;
    logic [tal_pkg::ROWW-1:0]        r_dot_row;
    logic [tal_pkg::KW-1:0]          r_k;

    logic signed [PW-1:0]            r_cx, r_cy, r_mx, r_my;
    logic [tal_pkg::LVW-1:0]         r_calpha;
    logic                            r_cin, r_clast, r_min_, r_mlast;
    logic [tal_pkg::COLW-1:0]        r_prod;

    logic                            r_ovalid;
    logic signed [PW-1:0]            r_ox, r_oy;
    logic [tal_pkg::COLW-1:0]        r_ocol;
    logic                            r_owe, r_ogl, r_old;

    // setup
    logic [tal_pkg::WW-1:0]          wsat;
    logic signed [PW-1:0]            dxp, dxn, dyp, dyn;
    logic [PW-1:0]                   adx, ady, maj_d, min_d;
    logic                            s1_dot, s1_swap, ord, dir_aa, dir_plain;
    logic signed [PW-1:0]            yf;
    logic                            div_done;
    logic [tal_pkg::QW-1:0]          div_quot;

    // pixel
    logic [tal_pkg::HW:0]            rr;
    logic [tal_pkg::KW-1:0]          kmax;
    logic signed [PW-1:0]            yi, minor, lx, ly;
    logic signed [5:0]               ddx, ddy;
    logic [3:0]                      dxa, dya;
    logic [7:0]                      d2, rr2, h2;
    logic [tal_pkg::TBLW-1:0]        ramp;
    logic signed [PW-1:0]            px, py;
    logic [tal_pkg::LVW-1:0]         alpha;
    logic                            in_disc, done_now, out_free;
    logic signed [tal_pkg::ERRW-1:0] e1;

    assign wsat = (i_line_width > tal_pkg::WW'(tal_pkg::MAX_WIDTH)) ?
                  tal_pkg::WW'(tal_pkg::MAX_WIDTH) : i_line_width;

    assign dxp   = r_x1 - r_x0;
    assign dxn   = r_x0 - r_x1;
    assign dyp   = r_y1 - r_y0;
    assign dyn   = r_y0 - r_y1;
    assign adx   = dxp[PW-1] ? dxn : dxp;
    assign ady   = dyp[PW-1] ? dyn : dyp;
    assign s1_dot  = (r_x0 == r_x1) && (r_y0 == r_y1);
    assign s1_swap = ady > adx;

    assign ord       = dxp[PW-1];
    assign maj_d     = adx;
    assign min_d     = ady;
    assign yf        = ord ? r_y1 : r_y0;
    assign dir_aa    = ord ? dyn[PW-1] : dyp[PW-1];
    assign dir_plain = ord ? (dyn[PW-1] || dyn == '0) : (dyp[PW-1] || dyp == '0);

    tal_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.setup2 && r_aa),
        .i_num   ({min_d[tal_pkg::DENW-1:0], 8'd0}),
        .i_den   (maj_d[tal_pkg::DENW-1:0]),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    always_comb begin
        rr    = r_aa ? {1'b0, r_half} + 1'b1 : {1'b0, r_half};
        yi    = r_min_fq[PW+7:8];
        ddx   = $signed({1'b0, r_k}) - $signed({2'b0, rr});
        ddy   = $signed({1'b0, r_dot_row}) - $signed({2'b0, rr});
        dxa   = ddx[5] ? 4'(-ddx) : ddx[3:0];
        dya   = ddy[5] ? 4'(-ddy) : ddy[3:0];
        d2    = 8'(dxa) * 8'(dxa) + 8'(dya) * 8'(dya);
        rr2   = 8'(rr) * 8'(rr);
        h2    = 8'(r_half) * 8'(r_half);
        ramp  = 12'({rr, 8'd0}) - 12'(rr) - tal_pkg::SQRT_TBL[d2[5:0]];
        minor = '0;
        kmax  = '0;
        px    = '0;
        py    = '0;
        alpha = 8'hFF;
        in_disc = 1'b1;
        case (r_mode)
            M_PLAIN: begin
                kmax  = {1'b0, r_half, 1'b0};
                minor = r_min_pos - PW'(r_half) + PW'(r_k);
            end
            M_AA: begin
                kmax  = {r_half, 2'b01};
                minor = yi - PW'(r_half) + PW'(r_k[tal_pkg::KW-1:1]) + PW'(r_k[0]);
                alpha = r_k[0] ? r_min_fq[7:0] : ~r_min_fq[7:0];
            end
            M_DOT: begin
                kmax = {rr, 1'b0};
                if (r_aa) begin
                    if (d2 >= rr2) begin
                        in_disc = 1'b0;
                    end else if (d2 > h2) begin
                        alpha = ramp[7:0];
                    end
                end
            end
            default: begin
                kmax = '0;
            end
        endcase
        lx = r_swap ? minor : r_maj_pos;
        ly = r_swap ? r_maj_pos : minor;
        if (r_mode == M_DOT) begin
            px = r_maj_pos + PW'(ddx);
            py = r_min_pos + PW'(ddy);
        end else begin
            px = lx;
            py = ly;
        end
        done_now = (r_mode == M_DOT) ? ({3'b0, r_dot_row} >= {3'b0, rr, 1'b0})
                                     : (r_maj_pos >= r_maj_fin);
        e1 = r_err - $signed({1'b0, r_min_d});
    end

    assign out_free = !r_ovalid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_IDLE;
        end else if (i_cmd.setup1 && s1_dot) begin
            r_mode <= M_DOT;
        end else if (i_cmd.setup2) begin
            r_mode <= r_aa ? M_AA : M_PLAIN;
        end else if (i_cmd.step_end && done_now) begin
            r_mode <= M_IDLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start_load) begin
            r_x0      <= PW'(i_x_start);
            r_y0      <= PW'(i_y_start);
            r_x1      <= PW'(i_x_end);
            r_y1      <= PW'(i_y_end);
            r_level   <= i_brightness;
            r_half    <= wsat[tal_pkg::WW-1:1];
            r_aa      <= i_antialias_on;
            r_dot_row <= '0;
        end
        if (i_cmd.setup1) begin
            if (s1_dot) begin
                r_swap    <= 1'b0;
                r_maj_pos <= r_x0;
                r_min_pos <= r_y0;
            end else begin
                r_swap <= s1_swap;
                if (s1_swap) begin
                    r_x0 <= r_y0;
                    r_y0 <= r_x0;
                    r_x1 <= r_y1;
                    r_y1 <= r_x1;
                end
            end
        end
        if (i_cmd.setup2) begin
            r_maj_d   <= maj_d;
            r_min_d   <= min_d;
            r_maj_pos <= ord ? r_x1 : r_x0;
            r_maj_fin <= ord ? r_x0 : r_x1;
            r_min_pos <= yf;
            r_min_fq  <= {{2{yf[PW-1]}}, yf, 8'd0};
            r_err     <= $signed({2'b0, maj_d[PW-1:1]});
            r_dir     <= r_aa ? dir_aa : dir_plain;
        end
        if (div_done) begin
            r_grad <= div_quot;
        end
        if (i_cmd.step_end) begin
            unique case (r_mode)
                M_DOT: begin
                    if (!done_now) begin
                        r_dot_row <= r_dot_row + 1'b1;
                    end
                end
                M_PLAIN: begin
                    if (e1 < 0) begin
                        r_min_pos <= r_dir ? r_min_pos - 1'b1 : r_min_pos + 1'b1;
                        r_err     <= e1 + $signed({1'b0, r_maj_d});
                    end else begin
                        r_err <= e1;
                    end
                    if (!done_now) begin
                        r_maj_pos <= r_maj_pos + 1'b1;
                    end
                end
                M_AA: begin
                    r_min_fq <= r_dir ? r_min_fq - $signed({15'd0, r_grad})
                                      : r_min_fq + $signed({15'd0, r_grad});
                    if (!done_now) begin
                        r_maj_pos <= r_maj_pos + 1'b1;
                    end
                end
                default: begin
                    r_dot_row <= r_dot_row;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.step_load) begin
            r_k <= '0;
        end else if (i_cmd.emit) begin
            r_k <= r_k + 1'b1;
        end
        if (i_cmd.calc) begin
            r_cx     <= px;
            r_cy     <= py;
            r_calpha <= alpha;
            r_cin    <= in_disc;
            r_clast  <= (r_k == kmax);
        end
        if (i_cmd.mul) begin
            r_mx    <= r_cx;
            r_my    <= r_cy;
            r_prod  <= r_level * r_calpha;
            r_min_  <= r_cin;
            r_mlast <= r_clast;
        end
        if (i_cmd.emit) begin
            r_ox   <= r_mx;
            r_oy   <= r_my;
            r_ocol <= r_min_ ? tal_pkg::grey565(tal_pkg::div255(r_prod)) : '0;
            r_owe  <= r_min_ && tal_pkg::on_screen(r_mx, r_my);
            r_ogl  <= r_mlast;
            r_old  <= r_mlast && done_now;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_ovalid <= 1'b1;
        end else if (!i_out_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    assign o_stat.mode_idle = (r_mode == M_IDLE);
    assign o_stat.dot       = s1_dot;
    assign o_stat.aa        = r_aa;
    assign o_stat.div_done  = div_done;
    assign o_stat.pix_last  = r_mlast;
    assign o_stat.out_free  = out_free;

    assign o_out_valid    = r_ovalid;
    assign o_pixel_x      = r_ox;
    assign o_pixel_y      = r_oy;
    assign o_pixel_color  = r_ocol;
    assign o_write_enable = r_owe;
    assign o_group_last   = r_ogl;
    assign o_line_done    = r_old;

endmodule
`default_nettype wire

@@ design/tal_ctrl.sv @@
`default_nettype none
module tal_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    input  wire logic           i_cmd,
    output logic                o_in_stall,
    output tal_pkg::t_cmd       o_cmd,
    input  wire tal_pkg::t_stat i_stat
);

    typedef enum logic [2:0] {
        S_IDLE, S_SETUP1, S_SETUP2, S_DIV, S_CALC, S_MUL, S_EMIT, S_END
    } t_state;

    t_state r_state, n_state;
    logic   r_stall, n_stall;
    logic   accept;

    assign accept = i_in_valid && !r_stall;

    always_comb begin
        o_cmd            = '0;
        o_cmd.start_load = accept && (i_cmd == tal_pkg::CMD_START);
        o_cmd.step_load  = accept && (i_cmd == tal_pkg::CMD_STEP) && !i_stat.mode_idle;
        o_cmd.setup1     = (r_state == S_SETUP1);
        o_cmd.setup2     = (r_state == S_SETUP2);
        o_cmd.calc       = (r_state == S_CALC);
        o_cmd.mul        = (r_state == S_MUL);
        o_cmd.emit       = (r_state == S_EMIT) && i_stat.out_free;
        o_cmd.step_end   = (r_state == S_END);
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (o_cmd.start_load) n_state = S_SETUP1;
                else if (o_cmd.step_load) n_state = S_CALC;
            end
            S_SETUP1: n_state = i_stat.dot ? S_IDLE : S_SETUP2;
            S_SETUP2: n_state = i_stat.aa ? S_DIV : S_IDLE;
            S_DIV: begin
                if (i_stat.div_done) n_state = S_IDLE;
            end
            S_CALC: n_state = S_MUL;
            S_MUL:  n_state = S_EMIT;
            S_EMIT: begin
                if (i_stat.out_free) n_state = i_stat.pix_last ? S_END : S_CALC;
            end
            S_END: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
        n_stall = (n_state != S_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_stall <= 1'b0;
        end else begin
            r_state <= n_state;
            r_stall <= n_stall;
        end
    end

    assign o_in_stall = r_stall;

endmodule
`default_nettype wire

@@ design/thick_antialiased_line_rasterizer_top.sv @@
// Line rasterizer producing RGB565 grey pixel writes. A start item (cmd 0) latches the
// endpoints, brightness and the width/antialias registers and sets the line up, and in
// antialiased mode also runs the 21-bit shift-subtract gradient divider. Each step item
// (cmd 1) emits one column or row: 2*half+1 pixels, twice that when antialiased, or 2*r+1
// for a dot row. Each pixel passes a calc, multiply and emit stage in turn, and the emit
// stage is held while the output is stalled; at most 30 pixels come from one step. Input
// stall stays high until the item is finished.
`default_nettype none
module thick_antialiased_line_rasterizer_top (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_in_valid,
    output logic                                      o_in_stall,
    input  wire logic                                 i_cmd,
    input  wire logic signed [tal_pkg::CW-1:0]        i_x_start,
    input  wire logic signed [tal_pkg::CW-1:0]        i_y_start,
    input  wire logic signed [tal_pkg::CW-1:0]        i_x_end,
    input  wire logic signed [tal_pkg::CW-1:0]        i_y_end,
    input  wire logic [tal_pkg::LVW-1:0]              i_brightness,
    output logic                                      o_out_valid,
    input  wire logic                                 i_out_stall,
    output logic signed [tal_pkg::PW-1:0]             o_pixel_x,
    output logic signed [tal_pkg::PW-1:0]             o_pixel_y,
    output logic [tal_pkg::COLW-1:0]                  o_pixel_color,
    output logic                                      o_write_enable,
    output logic                                      o_group_last,
    output logic                                      o_line_done,
    input  wire logic                                 i_cfg_we,
    input  wire logic [tal_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  wire logic [tal_pkg::WW-1:0]               i_cfg_data
);

    logic [tal_pkg::WW-1:0] r_line_width;
    logic                   r_antialias_on;
    tal_pkg::t_cmd          cmd;
    tal_pkg::t_stat         stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_width   <= tal_pkg::WW'(1);
            r_antialias_on <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                tal_pkg::CFG_LINE_WIDTH: r_line_width   <= i_cfg_data;
                tal_pkg::CFG_ANTIALIAS:  r_antialias_on <= i_cfg_data[0];
                default:                 r_line_width   <= r_line_width;
            endcase
        end
    end

    tal_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_cmd      (i_cmd),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd),
        .i_stat     (stat)
    );

    tal_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_x_start      (i_x_start),
        .i_y_start      (i_y_start),
        .i_x_end        (i_x_end),
        .i_y_end        (i_y_end),
        .i_brightness   (i_brightness),
        .i_line_width   (r_line_width),
        .i_antialias_on (r_antialias_on),
        .i_out_stall    (i_out_stall),
        .o_out_valid    (o_out_valid),
        .o_pixel_x      (o_pixel_x),
        .o_pixel_y      (o_pixel_y),
        .o_pixel_color  (o_pixel_color),
        .o_write_enable (o_write_enable),
        .o_group_last   (o_group_last),
        .o_line_done    (o_line_done)
    );

endmodule
`default_nettype wire

@@ design/tal_chk.sv @@
`default_nettype none
module tal_chk (
    input wire logic                             i_clk,
    input wire logic                             i_rst_n,
    input wire logic                             o_in_stall,
    input wire logic                             o_out_valid,
    input wire logic                             i_out_stall,
    input wire logic signed [tal_pkg::PW-1:0]    o_pixel_x,
    input wire logic signed [tal_pkg::PW-1:0]    o_pixel_y,
    input wire logic [tal_pkg::COLW-1:0]         o_pixel_color,
    input wire logic                             o_write_enable,
    input wire logic                             o_group_last,
    input wire logic                             o_line_done
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_pixel_x) &&
        $stable(o_pixel_y) && $stable(o_pixel_color) && $stable(o_group_last))
        else $error("stalled item changed");

    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_line_done |-> o_group_last)
        else $error("line end not at group end");

    a_we_screen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_write_enable |-> !o_pixel_x[tal_pkg::PW-1] &&
        !o_pixel_y[tal_pkg::PW-1] &&
        ($unsigned(o_pixel_x) < tal_pkg::PW'(tal_pkg::H_RES)) &&
        ($unsigned(o_pixel_y) < tal_pkg::PW'(tal_pkg::V_RES)))
        else $error("write enabled off screen");

    a_busy_mid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall && !o_group_last |=> o_in_stall)
        else $error("input taken mid group");

endmodule

bind thick_antialiased_line_rasterizer_top tal_chk u_tal_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_in_stall     (o_in_stall),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_pixel_x      (o_pixel_x),
    .o_pixel_y      (o_pixel_y),
    .o_pixel_color  (o_pixel_color),
    .o_write_enable (o_write_enable),
    .o_group_last   (o_group_last),
    .o_line_done    (o_line_done)
);
`default_nettype wire
